// ----- src/tkdm_pkg.sv -----
// Shared types and constants for the top-k distinct maximum tracker.
`default_nettype none

package tkdm_pkg;

    localparam int DATA_WIDTH   = 32;
    localparam int KEEP_W       = 5;
    localparam int MAX_KEEP_DEF = 16;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sample_value;
        logic                         end_of_case;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] kept_value;
        logic                         set_empty;
        logic                         last_of_run;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_DECIDE,
        ST_SHIFT,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMPTY
    } state_t;

endpackage

`default_nettype wire

// ----- src/tkdm_table.sv -----
// Sorted value table: synchronous RAM, one write and one registered read port.
`default_nettype none

module tkdm_table import tkdm_pkg::*; #(
    parameter int DEPTH = MAX_KEEP_DEF,
    parameter int AW    = 4
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [AW-1:0]                waddr,
    input  wire logic signed [DATA_WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]                raddr,
    output logic signed [DATA_WIDTH-1:0]      rdata
);

    logic signed [DATA_WIDTH-1:0] mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/top_k_distinct_max_tracker.sv -----
// Top level: keeps the k largest distinct values of a stream and emits them per case.
//
// Input channel in_valid/in_ready/in_data carries one sample or an end-of-case marker.
// Output channel out_valid/out_ready/out_data carries the held values, ascending,
// with last_of_run on the final one; an empty case gives one transaction with
// set_empty high. cfg_wr_en/cfg_wr_data write k (keep_count); the user must do so only
// while no transaction is in flight, as the block itself does not enforce it.
// The table lives in a one-port-write, one-port-read RAM with a registered read port.
// A sample is scanned against the held values (no scan when the table is empty), then
// decided, then placed once any entries in the way have moved to open a slot. An end
// item emits the held values one at a time: the scan loop walks the RAM read port one
// entry per cycle, while the emit loop reads on only after the output register empties.
// in_ready is high whenever the sequencer is idle, even while the last result
// still waits in the output register. A receiver stall holds the output
// register and pauses emission. Reset empties the table, drops any pending
// output and sets k to 16; the RAM contents are not cleared.
`default_nettype none

module top_k_distinct_max_tracker import tkdm_pkg::*; #(
    parameter int MAX_KEEP = MAX_KEEP_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_data,
    input  wire logic              cfg_wr_en,
    input  wire logic [KEEP_W-1:0] cfg_wr_data
);

    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int EW = (CW > KEEP_W) ? CW : KEEP_W;

    state_t                       state_reg, state_next;
    logic [KEEP_W-1:0]            keep_reg;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                idx_reg, idx_next;
    logic [CW-1:0]                pos_reg, pos_next;
    logic [CW-1:0]                place_reg, place_next;
    logic                         grow_reg, grow_next;
    logic                         dup_reg, dup_next;
    logic                         up_reg, up_next;
    logic                         chk_valid_reg, chk_valid_next;
    logic                         mv_valid_reg, mv_valid_next;
    logic [CW-1:0]                mv_dst_reg, mv_dst_next;
    logic signed [DATA_WIDTH-1:0] value_reg, value_next;
    logic                         out_valid_reg, out_valid_next;
    out_item_t                    out_item_reg, out_item_next;
    logic                         out_load;

    logic                         mem_we;
    logic [CW-1:0]                mem_waddr;
    logic signed [DATA_WIDTH-1:0] mem_wdata;
    logic [CW-1:0]                mem_raddr;
    logic signed [DATA_WIDTH-1:0] rd_data;

    logic [EW-1:0]                keep_ext;
    logic [EW-1:0]                keff_ext;
    logic                         table_full;
    logic [CW-1:0]                count_m1;
    logic                         in_fire;

    tkdm_table #(
        .DEPTH (MAX_KEEP),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr[AW-1:0]),
        .wdata (mem_wdata),
        .raddr (mem_raddr[AW-1:0]),
        .rdata (rd_data)
    );

    assign keep_ext   = EW'(keep_reg);
    assign keff_ext   = (keep_ext == '0) ? EW'(1) :
                        ((keep_ext > EW'(MAX_KEEP)) ? EW'(MAX_KEEP) : keep_ext);
    assign table_full = (EW'(count_reg) >= keff_ext);
    assign count_m1   = count_reg - CW'(1);
    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_item_reg;

    // write port: a pending move has priority over the final placement
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = mv_dst_reg;
        mem_wdata = rd_data;
        if (mv_valid_reg)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == ST_PLACE)
        begin
            mem_we    = 1'b1;
            mem_waddr = place_reg;
            mem_wdata = value_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        place_next     = place_reg;
        grow_next      = grow_reg;
        dup_next       = dup_reg;
        up_next        = up_reg;
        chk_valid_next = 1'b0;
        mv_valid_next  = 1'b0;
        mv_dst_next    = mv_dst_reg;
        value_next     = value_reg;
        mem_raddr      = idx_reg;
        out_load       = 1'b0;
        out_item_next  = out_item_reg;

        // accumulate the scan result in the cycle after the read
        if (chk_valid_reg)
        begin
            dup_next = dup_reg | (rd_data == value_reg);
            if (rd_data < value_reg)
            begin
                pos_next = pos_reg + CW'(1);
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    idx_next = '0;
                    if (in_data.end_of_case)
                    begin
                        state_next = (count_reg == '0) ? ST_EMPTY : ST_EMIT_RD;
                    end
                    else
                    begin
                        value_next = in_data.sample_value;
                        dup_next   = 1'b0;
                        pos_next   = '0;
                        state_next = (count_reg == '0) ? ST_DECIDE : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                chk_valid_next = 1'b1;
                if (idx_reg == count_m1)
                begin
                    state_next = ST_SCAN_WAIT;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_SCAN_WAIT:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (dup_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!table_full)
                begin
                    place_next = pos_reg;
                    grow_next  = 1'b1;
                    up_next    = 1'b1;
                    if (pos_reg == count_reg)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        idx_next   = count_m1;
                        state_next = ST_SHIFT;
                    end
                end
                else if (pos_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    place_next = pos_reg - CW'(1);
                    grow_next  = 1'b0;
                    up_next    = 1'b0;
                    if (pos_reg == CW'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        idx_next   = CW'(1);
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT:
            begin
                mv_valid_next = 1'b1;
                if (up_reg)
                begin
                    mv_dst_next = idx_reg + CW'(1);
                    if (idx_reg == place_reg)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        idx_next = idx_reg - CW'(1);
                    end
                end
                else
                begin
                    mv_dst_next = idx_reg - CW'(1);
                    if (idx_reg == place_reg)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            ST_PLACE:
            begin
                if (!mv_valid_reg)
                begin
                    if (grow_reg)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD:
            begin
                if (!out_valid_reg)
                begin
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                out_load                  = 1'b1;
                out_item_next.kept_value  = rd_data;
                out_item_next.set_empty   = 1'b0;
                out_item_next.last_of_run = (idx_reg == count_m1);
                if (idx_reg == count_m1)
                begin
                    count_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMPTY:
            begin
                if (!out_valid_reg)
                begin
                    out_load                  = 1'b1;
                    out_item_next.kept_value  = '0;
                    out_item_next.set_empty   = 1'b1;
                    out_item_next.last_of_run = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load | (out_valid_reg & ~out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            keep_reg      <= KEEP_RESET;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
            mv_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
            mv_valid_reg  <= mv_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                keep_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        place_reg    <= place_next;
        grow_reg     <= grow_next;
        dup_reg      <= dup_next;
        up_reg       <= up_next;
        mv_dst_reg   <= mv_dst_next;
        value_reg    <= value_next;
        out_item_reg <= out_item_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_KEEP))
        else $error("held count exceeds table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_valid_reg)
        else $error("output register overwritten before transaction completed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_RD || state_reg == ST_EMIT_LD || state_reg == ST_EMPTY)
        |-> !mem_we)
        else $error("table written during emission");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PLACE && !mv_valid_reg) |=> (state_reg == ST_IDLE))
        else $error("placement did not finish the sample");

endmodule

`default_nettype wire
